@@ src/bellman_ford_shortest_paths_core_defines.svh @@
// Assertion macros for the Bellman-Ford shortest paths core.
// Included by the top level; needs signals clk and rst_n in scope.
`ifndef BELLMAN_FORD_SHORTEST_PATHS_CORE_DEFINES_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_CORE_DEFINES_SVH
`ifndef SYNTH
`define BFSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BFSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BFSP_ASSERT_IMP(lbl, ante, cons, msg)
`define BFSP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/bfsp_pkg.sv @@
// Types and constants of the Bellman-Ford shortest paths core.
// No dependencies; used by bellman_ford_shortest_paths_core.
`timescale 1ns / 1ps

package bfsp_pkg;

  localparam int VTX_W  = 6;
  localparam int WGT_W  = 16;
  localparam int DIST_W = 24;

  localparam logic signed [DIST_W-1:0] UNREACHED = 24'sd9999;
  localparam logic signed [DIST_W-1:0] DIST_MAX  = 24'sh7FFFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN  = 24'sh800000;

  localparam logic CFG_VERTEX_COUNT  = 1'b0;
  localparam logic CFG_SOURCE_VERTEX = 1'b1;

  typedef struct packed {
    logic signed [WGT_W-1:0] weight;
    logic [VTX_W-1:0]        to_v;
    logic [VTX_W-1:0]        from_v;
  } edge_t;

endpackage

@@ src/bellman_ford_shortest_paths_core.sv @@
// Bellman-Ford single-source shortest paths core: edge store, distance and
// predecessor memories, and the sequencer that drives them. Uses bfsp_pkg.
// Edges load at one per cycle while idle. A last edge starts a run: distances are
// initialized, every edge is relaxed in each of vertex_count passes, a checking pass
// follows, then one result per vertex, or one flagged result on a negative cycle.
// Relaxation throughput is set by the read-compare-write of the distance memory.
// Synchronous active-low reset resets control state and configuration; the
// memories are not cleared, since each run rewrites the distances first.
`timescale 1ns / 1ps
`include "bellman_ford_shortest_paths_core_defines.svh"

module bellman_ford_shortest_paths_core #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // from_vertex[5:0], to_vertex[11:6], edge_weight[27:12]
  input  logic        in_tlast,   // last_edge
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // vertex_index[5:0], distance[29:6], predecessor[35:30]
  output logic        out_tlast,  // last_result
  output logic        out_tuser   // negative_cycle
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int DW = bfsp_pkg::DIST_W;
  localparam int PW = bfsp_pkg::VTX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_DIST_RD, S_RELAX, S_OUT_RD, S_OUT_LD, S_NEG
  } state_t;

  state_t state_r, state_nxt;
  logic [6:0]    vcount_r;
  logic [PW-1:0] src_r;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] ne_r, ne_nxt;
  logic [EW-1:0] k_r, k_nxt;
  logic [6:0]    pass_r, pass_nxt;
  logic          check_r, check_nxt;
  logic [6:0]    i_r, i_nxt;
  logic [6:0]    nv_r, nv_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [39:0]   out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_user_r, out_user_nxt;

  bfsp_pkg::edge_t edge_mem [MAX_EDGES];
  bfsp_pkg::edge_t edge_q_r;
  bfsp_pkg::edge_t in_edge;
  logic            edge_we;

  logic signed [DW-1:0] dist_mem [MAX_VERTICES];
  logic [PW-1:0]        pred_mem [MAX_VERTICES];
  logic signed [DW-1:0] dist_qa_r, dist_qb_r;
  logic [PW-1:0]        pred_q_r;
  logic [VW-1:0]        dist_ra, dist_rb, dist_wa;
  logic signed [DW-1:0] dist_wd;
  logic [PW-1:0]        pred_wd;
  logic                 dist_we;

  logic                 in_fire, slot_free, room, last_edge_k, relax_ok, relax_hit;
  logic [6:0]           nv_clamp;
  logic [DW:0]          sum;
  logic signed [DW-1:0] cand;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_edge   = bfsp_pkg::edge_t'(in_tdata[27:0]);
  assign room      = (fill_r < CW'(MAX_EDGES));
  assign edge_we   = in_fire && room;
  assign slot_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    if (vcount_r == 7'd0) begin
      nv_clamp = 7'd1;
    end else if (vcount_r > 7'(MAX_VERTICES)) begin
      nv_clamp = 7'(MAX_VERTICES);
    end else begin
      nv_clamp = vcount_r;
    end
  end

  assign sum = {dist_qa_r[DW-1], dist_qa_r} +
               {{(DW + 1 - bfsp_pkg::WGT_W){edge_q_r.weight[bfsp_pkg::WGT_W-1]}},
                edge_q_r.weight};

  always_comb begin
    if (sum[DW] != sum[DW-1]) begin
      cand = sum[DW] ? bfsp_pkg::DIST_MIN : bfsp_pkg::DIST_MAX;
    end else begin
      cand = sum[DW-1:0];
    end
  end

  assign relax_ok  = ({1'b0, edge_q_r.from_v} < nv_r) && ({1'b0, edge_q_r.to_v} < nv_r) &&
                     (dist_qa_r != bfsp_pkg::UNREACHED);
  assign relax_hit = relax_ok && (dist_qb_r > cand);
  assign last_edge_k = ((CW'(k_r) + CW'(1)) == ne_r);

  always_comb begin
    dist_ra = edge_q_r.from_v[VW-1:0];
    dist_rb = edge_q_r.to_v[VW-1:0];
    if (state_r == S_OUT_RD) begin
      dist_ra = i_r[VW-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ne_nxt        = ne_r;
    k_nxt         = k_r;
    pass_nxt      = pass_r;
    check_nxt     = check_r;
    i_nxt         = i_r;
    nv_nxt        = nv_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;
    dist_we       = 1'b0;
    dist_wa       = edge_q_r.to_v[VW-1:0];
    dist_wd       = cand;
    pred_wd       = edge_q_r.from_v;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tlast) begin
            nv_nxt    = nv_clamp;
            ne_nxt    = fill_r + CW'(room);
            fill_nxt  = '0;
            i_nxt     = '0;
            state_nxt = S_INIT;
          end else begin
            fill_nxt = fill_r + CW'(room);
          end
        end
      end
      S_INIT: begin
        dist_we = 1'b1;
        dist_wa = i_r[VW-1:0];
        dist_wd = (i_r == {1'b0, src_r}) ? '0 : bfsp_pkg::UNREACHED;
        pred_wd = '0;
        k_nxt   = '0;
        if (i_r == nv_r - 7'd1) begin
          i_nxt     = '0;
          pass_nxt  = '0;
          check_nxt = 1'b0;
          state_nxt = S_DIST_RD;
        end else begin
          i_nxt = i_r + 7'd1;
        end
      end
      S_DIST_RD: begin
        state_nxt = S_RELAX;
      end
      S_RELAX: begin
        dist_we   = relax_hit && !check_r;
        state_nxt = S_DIST_RD;
        if (check_r && relax_hit) begin
          state_nxt = S_NEG;
        end else if (last_edge_k) begin
          k_nxt = '0;
          if (check_r) begin
            i_nxt     = '0;
            state_nxt = S_OUT_RD;
          end else if (pass_r == nv_r - 7'd1) begin
            check_nxt = 1'b1;
          end else begin
            pass_nxt = pass_r + 7'd1;
          end
        end else begin
          k_nxt = k_r + EW'(1);
        end
      end
      S_OUT_RD: begin
        if (slot_free) begin
          state_nxt = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {4'b0, pred_q_r, dist_qa_r, PW'(i_r)};
        out_user_nxt  = 1'b0;
        out_last_nxt  = (i_r == nv_r - 7'd1);
        if (i_r == nv_r - 7'd1) begin
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_r + 7'd1;
          state_nxt = S_OUT_RD;
        end
      end
      S_NEG: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_user_nxt  = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= 7'd64;
      src_r       <= '0;
      fill_r      <= '0;
      ne_r        <= '0;
      k_r         <= '0;
      pass_r      <= '0;
      check_r     <= 1'b0;
      i_r         <= '0;
      nv_r        <= 7'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ne_r        <= ne_nxt;
      k_r         <= k_nxt;
      pass_r      <= pass_nxt;
      check_r     <= check_nxt;
      i_r         <= i_nxt;
      nv_r        <= nv_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      out_last_r  <= out_last_nxt;
      out_user_r  <= out_user_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          bfsp_pkg::CFG_VERTEX_COUNT:  vcount_r <= cfg_wdata;
          bfsp_pkg::CFG_SOURCE_VERTEX: src_r    <= cfg_wdata[PW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[fill_r[EW-1:0]] <= in_edge;
    end
    edge_q_r <= edge_mem[k_nxt];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
      pred_mem[dist_wa] <= pred_wd;
    end
    dist_qa_r <= dist_mem[dist_ra];
    dist_qb_r <= dist_mem[dist_rb];
    pred_q_r  <= pred_mem[dist_ra];
  end

  `BFSP_ASSERT_IMP(a_check_no_write, (state_r == S_RELAX) && check_r, !dist_we, "write in check pass")
  `BFSP_ASSERT_IMP(a_slot_free_on_load, state_r == S_OUT_LD, !out_valid_r, "result slot busy")
  `BFSP_ASSERT_IMP(a_neg_is_last, out_valid_r && out_user_r, out_last_r, "flagged result not last")
  `BFSP_ASSERT_IMP(a_edge_in_range, (state_r == S_DIST_RD) || (state_r == S_RELAX), CW'(k_r) < ne_r, "edge index out of range")
  `BFSP_ASSERT_NXT(a_run_starts, in_fire && in_tlast, state_r == S_INIT, "run did not start")

endmodule
